>>> design/ilo_pkg.sv
// ----------------------------------------------------------------------------
// ilo_pkg
// Shared constants, site tag type and saturation helpers for the Ising
// lattice observables unit.
// ----------------------------------------------------------------------------
package ilo_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int CFG_W     = 7;
   localparam int MAG_W     = 14;
   localparam int EN_W      = 15;
   // room for 2*N plus sign
   localparam int ACC_W     = 2 * SIDE_BITS + 3;

   localparam logic [CFG_W-1:0] SIDE_MIN   = CFG_W'(2);
   localparam logic [CFG_W-1:0] SIDE_MAX   = CFG_W'(MAX_SIDE);
   localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(64);

   localparam int MAG_HI = 2 ** (MAG_W - 1) - 1;
   localparam int MAG_LO = -(2 ** (MAG_W - 1));
   localparam int EN_HI  = 2 ** (EN_W - 1) - 1;
   localparam int EN_LO  = -(2 ** (EN_W - 1));

   // one loaded site, tagged with its place in the lattice
   typedef struct packed {
      logic valid;
      logic spin;
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
      logic last_site;
   } site_info_type;

   function automatic logic signed [MAG_W-1:0] sat_mag(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      if (w > MAG_HI) begin
         w = MAG_HI;
      end else if (w < MAG_LO) begin
         w = MAG_LO;
      end
      return MAG_W'(w);
   endfunction

   function automatic logic signed [EN_W-1:0] sat_en(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      if (w > EN_HI) begin
         w = EN_HI;
      end else if (w < EN_LO) begin
         w = EN_LO;
      end
      return EN_W'(w);
   endfunction

endpackage

>>> design/ising_lattice_observables_unit.sv
// ----------------------------------------------------------------------------
// ising_lattice_observables_unit
// Magnetization and periodic nearest-neighbor energy sums of an L by L
// lattice, fed one spin per transfer in row-major order.
// ----------------------------------------------------------------------------
// Throughput: one spin per cycle; busy never rises, a frame of L*L spins
//   can follow the previous one without a gap.
// Result path: the line buffer read and site tag are registered on the transfer
//   of the last spin, then the sums go into the output register, which also
//   holds the result strobe, so the strobe and the result rise together.
// Reset: side length 64, frame counters and sums cleared; the receiver cannot
//   stall and the strobe lasts one cycle.
module ising_lattice_observables_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_spin,
   input  logic                              csr_write_enable,
   input  logic [ilo_pkg::CFG_W-1:0]         csr_write_data,
   output logic                              rsp_valid,
   output logic signed [ilo_pkg::MAG_W-1:0]  rsp_magnetization_sum,
   output logic signed [ilo_pkg::EN_W-1:0]   rsp_energy_sum
);
   import ilo_pkg::*;

   logic                 accept;
   logic [SIDE_BITS-1:0] ram_addr;
   logic                 line_we, row0_we, up_spin, row0_spin;
   site_info_type        site;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ilo_site_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .spin             (req_spin),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ram_addr         (ram_addr),
      .line_we          (line_we),
      .row0_we          (row0_we),
      .site_ff          (site)
   );

   // read-before-write gives the spin one row up at the same column
   ilo_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .addr  (ram_addr),
      .wdata (req_spin),
      .rdata (up_spin)
   );

   ilo_ram #(.WIDTH(1), .DEPTH(MAX_SIDE)) u_row0_ram (
      .clock (clock),
      .we    (row0_we),
      .addr  (ram_addr),
      .wdata (req_spin),
      .rdata (row0_spin)
   );

   ilo_accum u_accum (
      .clock                 (clock),
      .reset                 (reset),
      .clear                 (csr_write_enable),
      .site                  (site),
      .up_spin               (up_spin),
      .row0_spin             (row0_spin),
      .rsp_valid             (rsp_valid),
      .rsp_magnetization_sum (rsp_magnetization_sum),
      .rsp_energy_sum        (rsp_energy_sum)
   );

endmodule

>>> design/ilo_ram.sv
// ----------------------------------------------------------------------------
// ilo_ram
// Generic single-port RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module ilo_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      rdata <= mem[addr];
      if (we) begin
         mem[addr] <= wdata;
      end
   end

endmodule

>>> design/ilo_site_scan.sv
// ----------------------------------------------------------------------------
// ilo_site_scan
// Side register, row/column counters and line buffer addressing. Tags each
// transferred spin with its lattice position, aligned with the RAM read data.
// ----------------------------------------------------------------------------
module ilo_site_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             spin,
   input  logic                             csr_write_enable,
   input  logic [ilo_pkg::CFG_W-1:0]        csr_write_data,
   output logic [ilo_pkg::SIDE_BITS-1:0]    ram_addr,
   output logic                             line_we,
   output logic                             row0_we,
   output ilo_pkg::site_info_type           site_ff
);
   import ilo_pkg::*;

   logic [CFG_W-1:0]     side_ff, side_in, side_eff;
   logic [SIDE_BITS-1:0] row_ff, row_in, col_ff, col_in, last_idx;
   site_info_type        site_in;

   always_comb begin
      if (side_ff < SIDE_MIN) begin
         side_eff = SIDE_MIN;
      end else if (side_ff > SIDE_MAX) begin
         side_eff = SIDE_MAX;
      end else begin
         side_eff = side_ff;
      end
      last_idx = SIDE_BITS'(side_eff - CFG_W'(1));

      site_in.valid     = accept;
      site_in.spin      = spin;
      site_in.first_row = (row_ff == '0);
      site_in.last_row  = (row_ff == last_idx);
      site_in.first_col = (col_ff == '0);
      site_in.last_col  = (col_ff == last_idx);
      site_in.last_site = site_in.last_row && site_in.last_col;

      side_in = side_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_write_enable) begin
         // new side restarts the frame
         side_in = csr_write_data;
         row_in  = '0;
         col_in  = '0;
      end else if (accept) begin
         if (site_in.last_col) begin
            col_in = '0;
            row_in = site_in.last_row ? '0 : row_ff + SIDE_BITS'(1);
         end else begin
            col_in = col_ff + SIDE_BITS'(1);
         end
      end
   end

   // line buffer holds the row above; row 0 copy serves the wrap of the last row
   assign ram_addr = col_ff;
   assign line_we  = accept;
   assign row0_we  = accept && site_in.first_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
         site_ff <= '0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         site_ff <= site_in;
      end
   end

endmodule

>>> design/ilo_accum.sv
// ----------------------------------------------------------------------------
// ilo_accum
// Adds each site's spin and its neighbor pair products into running sums and
// registers the saturated result at the end of a frame.
// ----------------------------------------------------------------------------
module ilo_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  ilo_pkg::site_info_type              site,
   input  logic                                up_spin,
   input  logic                                row0_spin,
   output logic                                rsp_valid,
   output logic signed [ilo_pkg::MAG_W-1:0]    rsp_magnetization_sum,
   output logic signed [ilo_pkg::EN_W-1:0]     rsp_energy_sum
);
   import ilo_pkg::*;

   localparam logic signed [ACC_W-1:0] PLUS  = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] MINUS = -ACC_W'(1);

   logic signed [ACC_W-1:0] mag_acc_ff, mag_acc_in, en_acc_ff, en_acc_in;
   logic signed [ACC_W-1:0] mag_step, en_step, mag_sum, en_sum;
   logic                    prev_ff, prev_in, first_ff, first_in;
   logic                    valid_ff, valid_in;
   logic signed [MAG_W-1:0] mag_ff, mag_in;
   logic signed [EN_W-1:0]  en_ff, en_in;

   // aligned spins give -1 to the energy, opposed ones +1
   function automatic logic signed [ACC_W-1:0] pair(input logic a, input logic b);
      return (a == b) ? MINUS : PLUS;
   endfunction

   always_comb begin
      mag_step = site.spin ? PLUS : MINUS;
      en_step  = '0;
      if (!site.first_row) en_step = en_step + pair(site.spin, up_spin);
      if (site.last_row)   en_step = en_step + pair(site.spin, row0_spin);
      if (!site.first_col) en_step = en_step + pair(site.spin, prev_ff);
      if (site.last_col)   en_step = en_step + pair(site.spin, first_ff);
      mag_sum = mag_acc_ff + mag_step;
      en_sum  = en_acc_ff + en_step;

      mag_acc_in = mag_acc_ff;
      en_acc_in  = en_acc_ff;
      prev_in    = prev_ff;
      first_in   = first_ff;
      valid_in   = 1'b0;
      mag_in     = mag_ff;
      en_in      = en_ff;
      if (clear) begin
         mag_acc_in = '0;
         en_acc_in  = '0;
      end else if (site.valid) begin
         prev_in = site.spin;
         if (site.first_col) first_in = site.spin;
         if (site.last_site) begin
            mag_acc_in = '0;
            en_acc_in  = '0;
            valid_in   = 1'b1;
            mag_in     = sat_mag(mag_sum);
            en_in      = sat_en(en_sum);
         end else begin
            mag_acc_in = mag_sum;
            en_acc_in  = en_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_acc_ff <= '0;
         en_acc_ff  <= '0;
         valid_ff   <= 1'b0;
      end else begin
         mag_acc_ff <= mag_acc_in;
         en_acc_ff  <= en_acc_in;
         valid_ff   <= valid_in;
      end
      prev_ff  <= prev_in;
      first_ff <= first_in;
      mag_ff   <= mag_in;
      en_ff    <= en_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_magnetization_sum = mag_ff;
   assign rsp_energy_sum        = en_ff;

endmodule
